// ----- hw/rtl/first_fit_block_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit block allocator
// Shared concurrent property forms, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define FFBA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Sizes, table entry layout, codes and control bundles of the allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int PAGE_SIZE  = 4096;
    localparam int MAX_PAGES  = 16;
    localparam int MAX_BLOCKS = 64;

    localparam int ST_W   = $clog2(MAX_PAGES * PAGE_SIZE);
    localparam int SZ_W   = $clog2(PAGE_SIZE + 1);
    localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CNT_W1 = CNT_W + 1;
    localparam int PU_W   = $clog2(MAX_PAGES + 1);

    typedef struct packed {
        logic [ST_W-1:0] start;
        logic [SZ_W-1:0] size;
        logic [PG_W-1:0] page;
        logic            used;
    } ffba_entry_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } ffba_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOSPACE  = 2'd1,
        STAT_BADSIZE  = 2'd2,
        STAT_NOTFOUND = 2'd3
    } ffba_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_APP0,
        S_APP1,
        S_RESP
    } ffba_state_t;

    typedef struct packed {
        logic rot;
        logic load;
    } ffba_cell_ctl_t;

    typedef struct packed {
        logic             rot;
        logic             load;
        logic [IDX_W-1:0] sel;
    } ffba_chain_ctl_t;

    function automatic logic [15:0] lo16(input logic [ST_W-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[15:0];
    endfunction

endpackage

// ----- hw/rtl/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Flow: a bad-size allocate goes straight to the result stage; any other
// request rotates the ring once over the whole table, may then append a page
// (allocated front block, then its free remainder), then loads the result register.
// Requests are taken one at a time, a new one only once the result register is loaded.
// Reset: table is empty, no pages taken, result channel idle.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] size, [31:16] address
    input  logic        s_tuser,   // [0] command
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [15:0] address_res, [17:16] status, [23:18] zero
);

    // The block table lives in a ring of cells. A request rotates the ring once:
    // cell 0 shows entry t while the pass counter is t, cell 1 shows entry t+1. Each rewritten
    // entry is loaded at cell MAX_BLOCKS-1-gap, where gap counts entries merged
    // away so far, so after the full turn every entry sits at its new index.
    // A split keeps one entry in flight (hold) and lets the free slot past the
    // last valid entry absorb the shift. Entries at or past the count are junk.

    ffba_pkg::ffba_state_t state_reg, state_next;

    logic [ffba_pkg::IDX_W-1:0] t_reg, t_next;
    logic [ffba_pkg::IDX_W-1:0] gap_reg, gap_next;
    logic [ffba_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [ffba_pkg::PU_W-1:0]  pu_reg, pu_next;

    ffba_pkg::ffba_cmd_t cmd_reg, cmd_next;
    logic [15:0]         size_reg, size_next;
    logic [15:0]         addr_reg, addr_next;

    ffba_pkg::ffba_entry_t hold_reg, hold_next;
    logic                  hold_v_reg, hold_v_next;
    logic                  found_reg, found_next;
    logic                  fail_reg, fail_next;
    logic                  split_reg, split_next;

    logic [15:0]          res_addr_reg, res_addr_next;
    ffba_pkg::ffba_stat_t res_stat_reg, res_stat_next;

    logic                 m_valid_reg, m_valid_next;
    logic [15:0]          m_addr_reg, m_addr_next;
    ffba_pkg::ffba_stat_t m_stat_reg, m_stat_next;

    ffba_pkg::ffba_chain_ctl_t chain_ctl;
    ffba_pkg::ffba_entry_t     load_data;
    ffba_pkg::ffba_entry_t     head;
    ffba_pkg::ffba_entry_t     second;

    ffba_chain u_chain (
        .aclk      (aclk),
        .ctl       (chain_ctl),
        .load_data (load_data),
        .head      (head),
        .second    (second)
    );

    // Request decode and per-cycle helpers
    logic                      in_acc;
    logic                      bad_size;
    logic                      in_live;
    logic                      nxt_live;
    logic                      fit;
    logic                      exact;
    logic                      tbl_full;
    logic                      room;
    logic [ffba_pkg::SZ_W-1:0] sz_e;
    logic [ffba_pkg::SZ_W-1:0] ps_e;
    logic [ffba_pkg::ST_W-1:0] page_start;
    ffba_pkg::ffba_entry_t     x_f;
    ffba_pkg::ffba_entry_t     y_f;
    ffba_pkg::ffba_entry_t     cur;

    assign s_tready = (state_reg == ffba_pkg::S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign bad_size = (s_tdata[15:0] == 16'd0) ||
                      (17'(s_tdata[15:0]) > 17'(ffba_pkg::PAGE_SIZE));

    assign in_live  = ffba_pkg::CNT_W'(t_reg) < cnt_reg;
    assign nxt_live = (ffba_pkg::CNT_W'(t_reg) + ffba_pkg::CNT_W'(1)) < cnt_reg;
    assign sz_e     = ffba_pkg::SZ_W'(size_reg);
    assign ps_e     = ffba_pkg::SZ_W'(ffba_pkg::PAGE_SIZE);
    assign fit      = !head.used && (17'(head.size) >= 17'(size_reg));
    assign exact    = 17'(head.size) == 17'(size_reg);
    assign tbl_full = cnt_reg == ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS);
    assign page_start = ffba_pkg::ST_W'(32'(pu_reg) * 32'(ffba_pkg::PAGE_SIZE));

    // A free page, and table room for the page block plus its remainder unless the request is a page
    assign room = (pu_reg < ffba_pkg::PU_W'(ffba_pkg::MAX_PAGES)) &&
                  (ffba_pkg::CNT_W1'(cnt_reg) +
                   ((sz_e == ps_e) ? ffba_pkg::CNT_W1'(1) : ffba_pkg::CNT_W1'(2))
                   <= ffba_pkg::CNT_W1'(ffba_pkg::MAX_BLOCKS));

    // Free: clear the used mark where the start matches the address; a held run absorbs the head
    always_comb begin
        x_f = head;
        y_f = second;
        if (ffba_pkg::lo16(head.start) == addr_reg) begin
            x_f.used = 1'b0;
        end
        if (ffba_pkg::lo16(second.start) == addr_reg) begin
            y_f.used = 1'b0;
        end
        cur = x_f;
        if (hold_v_reg) begin
            cur      = hold_reg;
            cur.size = hold_reg.size + x_f.size;
        end
    end

    always_comb begin
        state_next    = state_reg;
        t_next        = t_reg;
        gap_next      = gap_reg;
        cnt_next      = cnt_reg;
        pu_next       = pu_reg;
        cmd_next      = cmd_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        hold_next     = hold_reg;
        hold_v_next   = hold_v_reg;
        found_next    = found_reg;
        fail_next     = fail_reg;
        split_next    = split_reg;
        res_addr_next = res_addr_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_addr_next   = m_addr_reg;
        m_stat_next   = m_stat_reg;
        chain_ctl.rot  = 1'b0;
        chain_ctl.load = 1'b0;
        chain_ctl.sel  = ffba_pkg::IDX_W'(ffba_pkg::MAX_BLOCKS - 1) - gap_reg;
        load_data      = head;

        case (state_reg)
            ffba_pkg::S_IDLE: begin
                if (in_acc) begin
                    cmd_next      = ffba_pkg::ffba_cmd_t'(s_tuser);
                    size_next     = s_tdata[15:0];
                    addr_next     = s_tdata[31:16];
                    t_next        = '0;
                    gap_next      = '0;
                    hold_v_next   = 1'b0;
                    found_next    = 1'b0;
                    fail_next     = 1'b0;
                    split_next    = 1'b0;
                    res_addr_next = 16'd0;
                    if ((ffba_pkg::ffba_cmd_t'(s_tuser) == ffba_pkg::CMD_ALLOC) && bad_size) begin
                        res_stat_next = ffba_pkg::STAT_BADSIZE;
                        state_next    = ffba_pkg::S_RESP;
                    end else begin
                        state_next    = ffba_pkg::S_PASS;
                    end
                end
            end

            ffba_pkg::S_PASS: begin
                chain_ctl.rot = 1'b1;
                t_next        = t_reg + ffba_pkg::IDX_W'(1);
                if (cmd_reg == ffba_pkg::CMD_ALLOC) begin
                    if (in_live) begin
                        chain_ctl.load = 1'b1;
                        if (!found_reg && fit) begin
                            found_next    = 1'b1;
                            res_addr_next = ffba_pkg::lo16(head.start);
                            if (exact) begin
                                load_data.used = 1'b1;
                            end else if (tbl_full) begin
                                fail_next = 1'b1;
                            end else begin
                                // Split: front part used, remainder goes in flight
                                load_data.size   = sz_e;
                                load_data.used   = 1'b1;
                                hold_next.start  = head.start + ffba_pkg::ST_W'(sz_e);
                                hold_next.size   = head.size - sz_e;
                                hold_next.page   = head.page;
                                hold_next.used   = 1'b0;
                                hold_v_next      = 1'b1;
                                split_next       = 1'b1;
                            end
                        end else if (hold_v_reg) begin
                            load_data = hold_reg;
                            hold_next = head;
                        end
                    end else if (hold_v_reg) begin
                        // Drop the last in-flight entry into the first free slot
                        chain_ctl.load = 1'b1;
                        load_data      = hold_reg;
                        hold_v_next    = 1'b0;
                    end
                end else begin
                    if (in_live) begin
                        if (ffba_pkg::lo16(head.start) == addr_reg) begin
                            found_next = 1'b1;
                        end
                        if (nxt_live && !cur.used && !y_f.used && (cur.page == y_f.page)) begin
                            // Next entry merges in: hold the run, skip a slot
                            hold_next   = cur;
                            hold_v_next = 1'b1;
                            gap_next    = gap_reg + ffba_pkg::IDX_W'(1);
                        end else begin
                            chain_ctl.load = 1'b1;
                            load_data      = cur;
                            hold_v_next    = 1'b0;
                        end
                    end
                end

                if (t_reg == ffba_pkg::IDX_W'(ffba_pkg::MAX_BLOCKS - 1)) begin
                    state_next = ffba_pkg::S_RESP;
                    if (cmd_reg == ffba_pkg::CMD_FREE) begin
                        cnt_next      = cnt_reg - ffba_pkg::CNT_W'(gap_reg);
                        res_addr_next = 16'd0;
                        res_stat_next = found_next ? ffba_pkg::STAT_OK
                                                   : ffba_pkg::STAT_NOTFOUND;
                    end else if (found_next) begin
                        if (fail_next) begin
                            res_addr_next = 16'd0;
                            res_stat_next = ffba_pkg::STAT_NOSPACE;
                        end else begin
                            res_stat_next = ffba_pkg::STAT_OK;
                            if (split_next) begin
                                cnt_next = cnt_reg + ffba_pkg::CNT_W'(1);
                            end
                        end
                    end else if (room) begin
                        state_next = ffba_pkg::S_APP0;
                    end else begin
                        res_addr_next = 16'd0;
                        res_stat_next = ffba_pkg::STAT_NOSPACE;
                    end
                end
            end

            ffba_pkg::S_APP0: begin
                // Take a fresh page; the front of it is the allocated block
                chain_ctl.load  = 1'b1;
                chain_ctl.sel   = cnt_reg[ffba_pkg::IDX_W-1:0];
                load_data.start = page_start;
                load_data.size  = sz_e;
                load_data.page  = ffba_pkg::PG_W'(pu_reg);
                load_data.used  = 1'b1;
                hold_next       = load_data;
                cnt_next        = cnt_reg + ffba_pkg::CNT_W'(1);
                pu_next         = pu_reg + ffba_pkg::PU_W'(1);
                res_addr_next   = ffba_pkg::lo16(page_start);
                res_stat_next   = ffba_pkg::STAT_OK;
                state_next      = (sz_e == ps_e) ? ffba_pkg::S_RESP : ffba_pkg::S_APP1;
            end

            ffba_pkg::S_APP1: begin
                chain_ctl.load  = 1'b1;
                chain_ctl.sel   = cnt_reg[ffba_pkg::IDX_W-1:0];
                load_data.start = hold_reg.start + ffba_pkg::ST_W'(sz_e);
                load_data.size  = ps_e - sz_e;
                load_data.page  = hold_reg.page;
                load_data.used  = 1'b0;
                cnt_next        = cnt_reg + ffba_pkg::CNT_W'(1);
                state_next      = ffba_pkg::S_RESP;
            end

            ffba_pkg::S_RESP: begin
                // Advance once the result register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = res_addr_reg;
                    m_stat_next  = res_stat_reg;
                    state_next   = ffba_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffba_pkg::S_IDLE;
            t_reg       <= '0;
            gap_reg     <= '0;
            cnt_reg     <= '0;
            pu_reg      <= '0;
            hold_v_reg  <= 1'b0;
            found_reg   <= 1'b0;
            fail_reg    <= 1'b0;
            split_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            t_reg       <= t_next;
            gap_reg     <= gap_next;
            cnt_reg     <= cnt_next;
            pu_reg      <= pu_next;
            hold_v_reg  <= hold_v_next;
            found_reg   <= found_next;
            fail_reg    <= fail_next;
            split_reg   <= split_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        hold_reg     <= hold_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        m_addr_reg   <= m_addr_next;
        m_stat_reg   <= m_stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_stat_reg, m_addr_reg};

`include "first_fit_block_allocator_assert.svh"

    `FFBA_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS), "block count above table size")
    `FFBA_ASSERT_ALWAYS(a_gap_bound, gap_reg <= ffba_pkg::IDX_W'(2), "more than two merges in one free")
    `FFBA_ASSERT_ALWAYS(a_err_addr, !m_valid_reg || (m_stat_reg == ffba_pkg::STAT_OK) || (m_addr_reg == 16'd0), "failed request with nonzero address")
    `FFBA_ASSERT_NEXT(a_idle_hold, (state_reg == ffba_pkg::S_IDLE) && !in_acc, $stable(cnt_reg) && $stable(pu_reg), "table state moved while idle")

endmodule

// ----- hw/rtl/ffba_cell.sv -----
// ----------------------------------------------------------------------------
// ffba_cell
// One table slot: takes its neighbor's entry on rotate, or a direct load.
// ----------------------------------------------------------------------------
module ffba_cell (
    input  logic                   aclk,
    input  ffba_pkg::ffba_cell_ctl_t ctl,
    input  ffba_pkg::ffba_entry_t  nbr_in,
    input  ffba_pkg::ffba_entry_t  load_in,
    output ffba_pkg::ffba_entry_t  q
);

    ffba_pkg::ffba_entry_t e_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            e_reg <= load_in;
        end else if (ctl.rot) begin
            e_reg <= nbr_in;
        end
    end

    assign q = e_reg;

endmodule

// ----- hw/rtl/ffba_chain.sv -----
// ----------------------------------------------------------------------------
// ffba_chain
// Ring of table cells; rotates toward cell 0, one selected cell may load.
// ----------------------------------------------------------------------------
module ffba_chain (
    input  logic                    aclk,
    input  ffba_pkg::ffba_chain_ctl_t ctl,
    input  ffba_pkg::ffba_entry_t   load_data,
    output ffba_pkg::ffba_entry_t   head,
    output ffba_pkg::ffba_entry_t   second
);

    ffba_pkg::ffba_entry_t q [ffba_pkg::MAX_BLOCKS];

    for (genvar k = 0; k < ffba_pkg::MAX_BLOCKS; k++) begin : g_cell
        ffba_pkg::ffba_cell_ctl_t cctl;

        assign cctl.rot  = ctl.rot;
        assign cctl.load = ctl.load && (ctl.sel == ffba_pkg::IDX_W'(k));

        ffba_cell u_cell (
            .aclk    (aclk),
            .ctl     (cctl),
            .nbr_in  (q[(k + 1) % ffba_pkg::MAX_BLOCKS]),
            .load_in (load_data),
            .q       (q[k])
        );
    end

    assign head   = q[0];
    assign second = q[1];

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the first-fit block allocator. Allocate and free requests
// are streamed in; a block-table predictor computes each expected address
// and status, and a checker compares every result transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import ffba_pkg::*;

    typedef struct {
        int unsigned start;
        int unsigned size;
        int unsigned page;
        bit          used;
    } blk_t;

    typedef struct {
        logic [15:0] addr;
        ffba_stat_t  stat;
    } alloc_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] size, [31:16] address
    logic        s_tuser;   // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [15:0] address_res, [17:16] status, [23:18] zero

    // Predictor state: shadow of the block table
    blk_t          shadow_tbl[$];
    int unsigned   shadow_pages;
    alloc_result_t pending_results[$];
    int            mismatch_cnt;
    int            result_cnt;
    int            alloc_ok_cnt;
    int            free_ok_cnt;
    bit            hold_off;
    int            burst_left;

    first_fit_block_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Insert the free remainder after entry i, front part becomes used.
    function automatic void split_block(int i, int unsigned sz);
        blk_t rest;
        rest.start = shadow_tbl[i].start + sz;
        rest.size  = shadow_tbl[i].size - sz;
        rest.page  = shadow_tbl[i].page;
        rest.used  = 1'b0;
        shadow_tbl.insert(i + 1, rest);
        shadow_tbl[i].size = sz;
        shadow_tbl[i].used = 1'b1;
    endfunction

    function automatic alloc_result_t predict_alloc(int unsigned sz);
        alloc_result_t r;
        blk_t          pg;
        int            n;
        r.addr = '0;
        r.stat = STAT_OK;
        if (sz == 0 || sz > PAGE_SIZE) begin
            r.stat = STAT_BADSIZE;
            return r;
        end
        foreach (shadow_tbl[i]) begin
            if (!shadow_tbl[i].used && shadow_tbl[i].size >= sz) begin
                if (shadow_tbl[i].size == sz) begin
                    shadow_tbl[i].used = 1'b1;
                end else if (shadow_tbl.size() >= MAX_BLOCKS) begin
                    r.stat = STAT_NOSPACE;
                    return r;
                end else begin
                    split_block(i, sz);
                end
                r.addr = shadow_tbl[i].start[15:0];
                return r;
            end
        end
        // No fit: append a fresh page, with room for a split remainder.
        if (shadow_pages >= MAX_PAGES
                || shadow_tbl.size() + ((sz == PAGE_SIZE) ? 1 : 2) > MAX_BLOCKS) begin
            r.stat = STAT_NOSPACE;
            return r;
        end
        pg.start = shadow_pages * PAGE_SIZE;
        pg.size  = PAGE_SIZE;
        pg.page  = shadow_pages;
        pg.used  = (sz == PAGE_SIZE);
        shadow_tbl.push_back(pg);
        shadow_pages++;
        n = shadow_tbl.size() - 1;
        if (sz != PAGE_SIZE) split_block(n, sz);
        r.addr = shadow_tbl[n].start[15:0];
        return r;
    endfunction

    function automatic alloc_result_t predict_free(logic [15:0] a);
        alloc_result_t r;
        int            hit;
        int            k;
        r.addr = '0;
        r.stat = STAT_NOTFOUND;
        hit = -1;
        foreach (shadow_tbl[i]) begin
            if (hit < 0 && shadow_tbl[i].start[15:0] == a) hit = i;
        end
        if (hit < 0) return r;
        r.stat = STAT_OK;
        shadow_tbl[hit].used = 1'b0;
        // Coalesce adjacent free blocks of the same page.
        k = 0;
        while (k + 1 < shadow_tbl.size()) begin
            if (!shadow_tbl[k].used && !shadow_tbl[k+1].used
                    && shadow_tbl[k].page == shadow_tbl[k+1].page) begin
                shadow_tbl[k].size += shadow_tbl[k+1].size;
                shadow_tbl.delete(k + 1);
            end else begin
                k++;
            end
        end
        return r;
    endfunction

    // Drive one request; gaps between bursts of random length.
    // Valid stays high after a transfer until the next request or gap drives it.
    task automatic send_request(ffba_cmd_t cmd, logic [15:0] sz, logic [15:0] a);
        alloc_result_t r;
        int unsigned   gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {a, sz};
        do @(posedge aclk); while (!s_tready);
        r = (cmd == CMD_ALLOC) ? predict_alloc(sz) : predict_free(a);
        pending_results.push_back(r);
    endtask

    // Pick a start address that currently exists in the table, if any.
    function automatic logic [15:0] live_addr();
        if (shadow_tbl.size() == 0) return 16'($urandom);
        return shadow_tbl[$urandom_range(0, shadow_tbl.size() - 1)].start[15:0];
    endfunction

    task automatic test_directed();
        send_request(CMD_ALLOC, 16'd0, 16'hFFFF);         // zero size
        send_request(CMD_ALLOC, 16'hFFFF, 16'h0000);      // far over a page
        send_request(CMD_ALLOC, 16'(PAGE_SIZE + 1), 16'h5555);
        send_request(CMD_FREE, 16'hAAAA, 16'h0000);       // unknown on empty table
        send_request(CMD_ALLOC, 16'(PAGE_SIZE), 16'h0);   // whole page, exact
        send_request(CMD_ALLOC, 16'd1, 16'h0);            // new page, split
        send_request(CMD_ALLOC, 16'd100, 16'h0);          // split inside page
        send_request(CMD_ALLOC, 16'(PAGE_SIZE - 101), 16'h0); // exact remainder fit
        send_request(CMD_FREE, 16'h0, 16'(PAGE_SIZE + 1)); // free middle
        send_request(CMD_FREE, 16'h0, 16'(PAGE_SIZE + 1)); // free of a free block
        send_request(CMD_FREE, 16'h0, 16'(PAGE_SIZE));     // merge with neighbor
        send_request(CMD_ALLOC, 16'd1, 16'h0);             // reuse merged block
        send_request(CMD_FREE, 16'h0, 16'h0);
        send_request(CMD_FREE, 16'h0, 16'h0003);           // not a start
        send_request(CMD_FREE, 16'h0, 16'(PAGE_SIZE + 101));
        send_request(CMD_FREE, 16'h0, 16'(PAGE_SIZE));
    endtask

    // Exhaust pages, release a few, fill the table with small splits until full, then free some.
    task automatic test_exhaustion();
        repeat (20) send_request(CMD_ALLOC, 16'(PAGE_SIZE), 16'h0);
        repeat (4) send_request(CMD_FREE, 16'h0, live_addr());
        repeat (70) send_request(CMD_ALLOC, 16'($urandom_range(1, 8)), 16'h0);
        repeat (40) send_request(CMD_FREE, 16'h0, live_addr());
    endtask

    // Long receiver hold-off while requests keep coming.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (1500) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (12) send_request(CMD_ALLOC, 16'($urandom_range(1, 300)), 16'h0);
        join
    endtask

    task automatic test_random(int n);
        int unsigned sel;
        logic [15:0] sz;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                sz = (sel < 5) ? 16'($urandom) : 16'($urandom_range(1, PAGE_SIZE));
                if (sel >= 40) sz = 16'($urandom_range(1, 64));
                send_request(CMD_ALLOC, sz, 16'($urandom));
            end else if (sel < 92) begin
                send_request(CMD_FREE, 16'($urandom), live_addr());
            end else begin
                send_request(CMD_FREE, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    // Receiver stall pattern: runs of ready and not-ready of random length.
    initial begin
        int unsigned run;
        m_tready = 1'b0;
        forever begin
            run = $urandom_range(1, 40);
            repeat (run) begin
                @(posedge aclk);
                m_tready <= !hold_off;
            end
            run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
            repeat (run) begin
                @(posedge aclk);
                m_tready <= 1'b0;
            end
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        alloc_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            result_cnt++;
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("ERROR: unexpected result %h", m_tdata);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[15:0] !== exp_r.addr || m_tdata[17:16] !== exp_r.stat
                        || m_tdata[23:18] !== 6'd0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: result %0d exp addr %h stat %0d, got addr %h stat %0d",
                                 result_cnt, exp_r.addr, exp_r.stat,
                                 m_tdata[15:0], m_tdata[17:16]);
                end else if (exp_r.stat == STAT_OK && exp_r.addr != 0) begin
                    alloc_ok_cnt++;
                end else if (exp_r.stat == STAT_OK) begin
                    free_ok_cnt++;
                end
            end
        end
    end

    initial begin
        #30ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int drain;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        hold_off     = 1'b0;
        burst_left   = 0;
        shadow_pages = 0;
        mismatch_cnt = 0;
        result_cnt   = 0;
        alloc_ok_cnt = 0;
        free_ok_cnt  = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_exhaustion();
        test_backpressure();
        test_random(1200);
        s_tvalid <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 200000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (100) @(posedge aclk);
        $display("Covered %0d results: %0d nonzero allocations, %0d other ok, pages used %0d",
                 result_cnt, alloc_ok_cnt, free_ok_cnt, shadow_pages);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- first_fit_block_allocator.f -----
+incdir+hw/rtl
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_cell.sv
hw/rtl/ffba_chain.sv
hw/rtl/first_fit_block_allocator.sv
sim/tb_top.sv
